// File: hdl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants shared by the round-robin task scheduler modules.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int NUM_TASKS = 32;
	localparam int TASK_W    = $clog2(NUM_TASKS);
	localparam int CNT_W     = $clog2(NUM_TASKS + 1);

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_RUN    = 2'd1,
		CMD_SWITCH = 2'd2,
		CMD_SLEEP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_NOT_ACTIVE = 2'd2,
		ST_ALREADY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SLOT_FREE   = 2'd0,
		SLOT_ALLOC  = 2'd1,
		SLOT_ACTIVE = 2'd2
	} slot_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC,
		S_RUN,
		S_SWITCH,
		S_SLEEP_CHK,
		S_SLEEP_CUR,
		S_SLEEP_FIND,
		S_SLEEP_SHIFT,
		S_SLEEP_TAIL,
		S_JUMP,
		S_DONE
	} fsm_state_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [4:0]  task_id;
	} req_t;

	typedef struct packed {
		logic [4:0]  result_task;
		logic        jump;
		status_t     status;
		logic [5:0]  run_count;
	} rsp_t;

	typedef struct packed {
		logic              en;
		logic [TASK_W-1:0] addr;
		slot_state_t       data;
	} slot_wr_t;

	typedef struct packed {
		logic              en;
		logic [TASK_W-1:0] addr;
		logic [TASK_W-1:0] data;
	} list_wr_t;

endpackage

// File: hdl/round_robin_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Task slot table and round-robin run list under a small command sequencer.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_t  (cmd, task_id)
//   rsp      out        rsp_valid / rsp_ready  rsp_t  (result_task, jump,
//                                                      status, run_count)
//
// One command is worked at a time; table reads are combinational.
// Alloc walks the slot table one slot per cycle.
// Sleep walks and compacts the run list one entry per cycle.
// Reset leaves slot 0 active and alone in the run list.
// The response register holds one result; a stalled rsp holds the next
// command in its final state until the register frees.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rrts_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rrts_pkg::rsp_t rsp
);
	import rrts_pkg::*;

	fsm_state_t        state_q, state_d;
	logic [TASK_W-1:0] tid_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [TASK_W-1:0] pos_q;
	logic [TASK_W-1:0] res_q;
	logic              jmp_q;
	status_t           st_q;
	logic              cur_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [TASK_W-1:0] slot_rd_addr;
	slot_state_t       slot_rd;
	slot_wr_t          slot_wr;
	logic [TASK_W-1:0] list_rd_addr;
	logic [TASK_W-1:0] list_rd;
	list_wr_t          list_wr;

	logic              slot_free;
	logic              slot_active;
	logic              alloc_last;
	logic              idx_in_list;
	logic              list_hit;
	logic              pos_in_list;
	logic              run_ok;
	logic [CNT_W-1:0]  pos_inc;
	logic              rsp_load;

	rrts_slot_table u_slot_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (slot_rd_addr),
		.rd_data (slot_rd),
		.wr      (slot_wr)
	);

	rrts_run_list u_run_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (list_rd_addr),
		.rd_data (list_rd),
		.wr      (list_wr)
	);

	assign slot_free   = (slot_rd == SLOT_FREE);
	assign slot_active = (slot_rd == SLOT_ACTIVE);
	assign alloc_last  = (idx_q[TASK_W-1:0] == TASK_W'(NUM_TASKS - 1));
	assign idx_in_list = (idx_q < count_q);
	assign list_hit    = (list_rd == tid_q);
	assign pos_in_list = ({1'b0, pos_q} < count_q);
	assign run_ok      = !slot_active && (count_q < CNT_W'(NUM_TASKS));
	assign pos_inc     = {1'b0, pos_q} + CNT_W'(1);
	assign rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (req.cmd)
						CMD_ALLOC:  state_d = S_ALLOC;
						CMD_RUN:    state_d = S_RUN;
						CMD_SWITCH: state_d = S_SWITCH;
						CMD_SLEEP:  state_d = S_SLEEP_CHK;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_ALLOC: begin
				if (slot_free || alloc_last) begin
					state_d = S_DONE;
				end
			end
			S_RUN:       state_d = S_DONE;
			S_SWITCH:    state_d = (count_q > CNT_W'(1)) ? S_JUMP : S_DONE;
			S_SLEEP_CHK: state_d = slot_active ? S_SLEEP_CUR : S_DONE;
			S_SLEEP_CUR: state_d = S_SLEEP_FIND;
			S_SLEEP_FIND: begin
				if (!idx_in_list) begin
					state_d = S_SLEEP_TAIL;
				end else if (list_hit) begin
					state_d = S_SLEEP_SHIFT;
				end
			end
			S_SLEEP_SHIFT: begin
				if (!idx_in_list) begin
					state_d = S_SLEEP_TAIL;
				end
			end
			S_SLEEP_TAIL: begin
				state_d = (cur_q && (count_q != '0)) ? S_JUMP : S_DONE;
			end
			S_JUMP: state_d = S_DONE;
			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		slot_rd_addr = tid_q;
		slot_wr      = '{en: 1'b0, addr: tid_q, data: SLOT_ALLOC};
		list_rd_addr = pos_q;
		list_wr      = '{en: 1'b0, addr: idx_q[TASK_W-1:0], data: list_rd};
		unique case (state_q)
			S_ALLOC: begin
				slot_rd_addr = idx_q[TASK_W-1:0];
				slot_wr      = '{en: slot_free, addr: idx_q[TASK_W-1:0],
				                 data: SLOT_ALLOC};
			end
			S_RUN: begin
				slot_wr = '{en: run_ok, addr: tid_q, data: SLOT_ACTIVE};
				list_wr = '{en: run_ok, addr: count_q[TASK_W-1:0], data: tid_q};
			end
			S_SLEEP_CHK: begin
				slot_wr = '{en: slot_active, addr: tid_q, data: SLOT_ALLOC};
			end
			S_SLEEP_FIND: begin
				list_rd_addr = idx_q[TASK_W-1:0];
			end
			S_SLEEP_SHIFT: begin
				list_rd_addr = idx_q[TASK_W-1:0] + TASK_W'(1);
				list_wr      = '{en: idx_in_list, addr: idx_q[TASK_W-1:0],
				                 data: list_rd};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= CNT_W'(1);
			pos_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_RUN: begin
					if (run_ok) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				S_SWITCH: begin
					if (count_q > CNT_W'(1)) begin
						pos_q <= (pos_inc >= count_q) ? '0 : pos_inc[TASK_W-1:0];
					end
				end
				S_SLEEP_FIND: begin
					if (idx_in_list && list_hit) begin
						count_q <= count_q - CNT_W'(1);
						if (idx_q < {1'b0, pos_q}) begin
							pos_q <= pos_q - TASK_W'(1);
						end
					end
				end
				S_SLEEP_TAIL: begin
					if (cur_q && !pos_in_list) begin
						pos_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					tid_q <= req.task_id;
					idx_q <= '0;
					res_q <= '0;
					jmp_q <= 1'b0;
					st_q  <= ST_OK;
					cur_q <= 1'b0;
				end
			end
			S_ALLOC: begin
				if (slot_free) begin
					res_q <= idx_q[TASK_W-1:0];
				end else if (alloc_last) begin
					st_q <= ST_FULL;
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			S_RUN: begin
				if (slot_active) begin
					st_q <= ST_ALREADY;
				end
			end
			S_SLEEP_CHK: begin
				if (!slot_active) begin
					st_q <= ST_NOT_ACTIVE;
				end
			end
			S_SLEEP_CUR: begin
				cur_q <= pos_in_list && list_hit;
			end
			S_SLEEP_FIND: begin
				if (idx_in_list && !list_hit) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			S_SLEEP_SHIFT: begin
				if (idx_in_list) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			S_JUMP: begin
				res_q <= list_rd;
				jmp_q <= 1'b1;
			end
			S_DONE: begin
				if (rsp_load) begin
					rsp_q <= '{result_task: res_q, jump: jmp_q, status: st_q,
					           run_count: count_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/rrts_slot_table.sv
// ----------------------------------------------------------------------------
// rrts_slot_table
// Per-slot state store: one read address, one write port, slot 0 active
// after reset.
// ----------------------------------------------------------------------------
module rrts_slot_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [rrts_pkg::TASK_W-1:0]      rd_addr,
	output rrts_pkg::slot_state_t            rd_data,
	input  rrts_pkg::slot_wr_t               wr
);
	import rrts_pkg::*;

	slot_state_t slot_q [NUM_TASKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				slot_q[i] <= (i == 0) ? SLOT_ACTIVE : SLOT_FREE;
			end
		end else if (wr.en) begin
			slot_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = slot_q[rd_addr];

endmodule

// File: hdl/rrts_run_list.sv
// ----------------------------------------------------------------------------
// rrts_run_list
// Ordered list of active tasks: one read address, one write port.
// ----------------------------------------------------------------------------
module rrts_run_list (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [rrts_pkg::TASK_W-1:0]      rd_addr,
	output logic [rrts_pkg::TASK_W-1:0]      rd_data,
	input  rrts_pkg::list_wr_t               wr
);
	import rrts_pkg::*;

	logic [TASK_W-1:0] list_q [NUM_TASKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				list_q[i] <= '0;
			end
		end else if (wr.en) begin
			list_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = list_q[rd_addr];

endmodule
